// ===== src/nfg_pkg.sv =====
`default_nettype none

package nfg_pkg;

  // field widths
  localparam int CoordW   = 24;
  localparam int DiffW    = CoordW + 1;
  localparam int DistW    = 50;
  localparam int IdxW     = 10;
  localparam int RankW    = 2;
  localparam int NumSlots = 4;
  localparam int LimW     = 17;

  // grid size defaults
  localparam int NFG_MAX_ROWS = 1024;
  localparam int NFG_MAX_COLS = 1024;

  // default radius: 100 km in dm, squared
  localparam logic [DistW-1:0] RadiusDm    = DistW'(100000 * 10);
  localparam logic [DistW-1:0] RadiusReset = RadiusDm * RadiusDm;

  // request codes
  localparam logic ReqQuery = 1'b0;
  localparam logic ReqPoint = 1'b1;

  // accepted input word
  typedef struct packed {
    logic                     req_type;
    logic signed [CoordW-1:0] north;
    logic signed [CoordW-1:0] east;
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic                     last;
  } nfg_item_t;

  // squared terms headed for the rank stage
  typedef struct packed {
    logic             valid;
    logic             query;
    logic             rank_en;
    logic             emit;
    logic [DistW-1:0] sq_n;
    logic [DistW-1:0] sq_e;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
  } nfg_pt_t;

  // four ranked slots, nearest first
  typedef struct packed {
    logic [NumSlots-1:0][DistW-1:0] dsq;
    logic [NumSlots-1:0][IdxW-1:0]  row;
    logic [NumSlots-1:0][IdxW-1:0]  col;
    logic [NumSlots-1:0]            filled;
  } nfg_slots_t;

endpackage

`default_nettype wire

// ===== src/nfg_in_if.sv =====
`default_nettype none

interface nfg_in_if import nfg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [CoordW-1:0] coord_north;
  logic signed [CoordW-1:0] coord_east;
  logic [IdxW-1:0]          point_row;
  logic [IdxW-1:0]          point_col;
  logic                     last_point;

  modport source (
    output valid, req_type, coord_north, coord_east, point_row, point_col, last_point,
    input  ready
  );
  modport sink (
    input  valid, req_type, coord_north, coord_east, point_row, point_col, last_point,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/nfg_out_if.sv =====
`default_nettype none

interface nfg_out_if import nfg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RankW-1:0] rank;
  logic [IdxW-1:0]  near_row;
  logic [IdxW-1:0]  near_col;
  logic [DistW-1:0] dist_squared;
  logic             found;
  logic             last_result;

  modport source (
    output valid, rank, near_row, near_col, dist_squared, found, last_result,
    input  ready
  );
  modport sink (
    input  valid, rank, near_row, near_col, dist_squared, found, last_result,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/nfg_dist.sv =====
`default_nettype none

module nfg_dist import nfg_pkg::*; #(
  parameter int MAX_ROWS = NFG_MAX_ROWS,
  parameter int MAX_COLS = NFG_MAX_COLS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      take,
  input  wire nfg_item_t item,
  output nfg_pt_t        pt
);

  localparam logic [LimW-1:0] RowLim = LimW'(MAX_ROWS);
  localparam logic [LimW-1:0] ColLim = LimW'(MAX_COLS);

  logic                     s1_valid_r;
  nfg_item_t                s1_r;
  logic signed [CoordW-1:0] probe_n_r;
  logic signed [CoordW-1:0] probe_e_r;
  logic signed [DiffW-1:0]  dn;
  logic signed [DiffW-1:0]  de;
  logic signed [DistW-1:0]  prod_n;
  logic signed [DistW-1:0]  prod_e;
  logic                     on_grid;
  nfg_pt_t                  s2_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      s1_r <= item;
    end
  end

  // probe position, latched as a query leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_n_r <= '0;
      probe_e_r <= '0;
    end else if (adv && s1_valid_r && s1_r.req_type == ReqQuery) begin
      probe_n_r <= s1_r.north;
      probe_e_r <= s1_r.east;
    end
  end

  // offsets and squares
  always_comb begin
    dn      = DiffW'(s1_r.north) - DiffW'(probe_n_r);
    de      = DiffW'(s1_r.east) - DiffW'(probe_e_r);
    prod_n  = DistW'(dn) * DistW'(dn);
    prod_e  = DistW'(de) * DistW'(de);
    on_grid = (LimW'(s1_r.row) < RowLim) && (LimW'(s1_r.col) < ColLim);
  end

  // square register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r.valid   <= s1_valid_r;
      s2_r.query   <= (s1_r.req_type == ReqQuery);
      s2_r.rank_en <= (s1_r.req_type == ReqPoint) && on_grid;
      s2_r.emit    <= (s1_r.req_type == ReqPoint) && s1_r.last;
      s2_r.sq_n    <= prod_n;
      s2_r.sq_e    <= prod_e;
      s2_r.row     <= s1_r.row;
      s2_r.col     <= s1_r.col;
    end
  end

  assign pt = s2_r;

endmodule

`default_nettype wire

// ===== src/nfg_rank.sv =====
`default_nettype none

module nfg_rank import nfg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire nfg_pt_t          pt,
  input  wire logic [DistW-1:0] radius,
  output nfg_slots_t            slots,
  output nfg_slots_t            slots_nxt
);

  nfg_slots_t          slots_r;
  logic [DistW-1:0]    d;
  logic [NumSlots-1:0] lt;

  // compare against every slot and insert; slots are kept sorted,
  // so the less-than flags form a thermometer code
  always_comb begin
    d         = pt.sq_n + pt.sq_e;
    slots_nxt = slots_r;
    for (int k = 0; k < NumSlots; k++) begin
      lt[k] = d < slots_r.dsq[k];
    end
    if (pt.query) begin
      for (int k = 0; k < NumSlots; k++) begin
        slots_nxt.dsq[k]    = radius;
        slots_nxt.row[k]    = '0;
        slots_nxt.col[k]    = '0;
        slots_nxt.filled[k] = 1'b0;
      end
    end else if (pt.rank_en) begin
      if (lt[0]) begin
        slots_nxt.dsq[0]    = d;
        slots_nxt.row[0]    = pt.row;
        slots_nxt.col[0]    = pt.col;
        slots_nxt.filled[0] = 1'b1;
      end
      for (int k = 1; k < NumSlots; k++) begin
        if (lt[k-1]) begin
          slots_nxt.dsq[k]    = slots_r.dsq[k-1];
          slots_nxt.row[k]    = slots_r.row[k-1];
          slots_nxt.col[k]    = slots_r.col[k-1];
          slots_nxt.filled[k] = slots_r.filled[k-1];
        end else if (lt[k]) begin
          slots_nxt.dsq[k]    = d;
          slots_nxt.row[k]    = pt.row;
          slots_nxt.col[k]    = pt.col;
          slots_nxt.filled[k] = 1'b1;
        end
      end
    end
  end

  // slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NumSlots; k++) begin
        slots_r.dsq[k]    <= RadiusReset;
        slots_r.row[k]    <= '0;
        slots_r.col[k]    <= '0;
        slots_r.filled[k] <= 1'b0;
      end
    end else if (adv && pt.valid) begin
      slots_r <= slots_nxt;
    end
  end

  assign slots = slots_r;

endmodule

`default_nettype wire

// ===== src/nfg_emit.sv =====
`default_nettype none

module nfg_emit import nfg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire nfg_slots_t slots_nxt,
  nfg_out_if.source       out_bus,
  output logic            busy
);

  localparam logic [RankW-1:0] LastRank = RankW'(NumSlots - 1);

  nfg_slots_t       buf_r;
  logic             found_r;
  logic [RankW-1:0] idx_r;
  logic             busy_r;
  logic             all_filled;
  logic             taken;

  assign all_filled = &slots_nxt.filled;
  assign taken      = busy_r && out_bus.ready;

  // snapshot of the slots; indices zeroed when not all were filled
  always_ff @(posedge clk) begin
    if (load) begin
      found_r <= all_filled;
      for (int k = 0; k < NumSlots; k++) begin
        buf_r.dsq[k]    <= slots_nxt.dsq[k];
        buf_r.row[k]    <= all_filled ? slots_nxt.row[k] : '0;
        buf_r.col[k]    <= all_filled ? slots_nxt.col[k] : '0;
        buf_r.filled[k] <= slots_nxt.filled[k];
      end
    end
  end

  // drain counter, one word per handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (taken) begin
      idx_r <= idx_r + RankW'(1);
      if (idx_r == LastRank) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid        = busy_r;
  assign out_bus.rank         = idx_r;
  assign out_bus.near_row     = buf_r.row[idx_r];
  assign out_bus.near_col     = buf_r.col[idx_r];
  assign out_bus.dist_squared = buf_r.dsq[idx_r];
  assign out_bus.found        = found_r && buf_r.filled[idx_r];
  assign out_bus.last_result  = (idx_r == LastRank);
  assign busy                 = busy_r;

endmodule

`default_nettype wire

// ===== src/nearest_four_grid_search.sv =====
`default_nettype none

// Channel   Dir  Handshake      Word
// in_bus    in   valid/ready    req_type, coord_north, coord_east, point_row,
//                               point_col, last_point
// out_bus   out  valid/ready    rank, near_row, near_col, dist_squared, found,
//                               last_result
// cfg_      in   cfg_we         cfg_wdata = radius_squared
//
// One input word per cycle while no last point stalls on a busy result buffer.
// A word passes an input register, a square register and the slot registers; a
// last point's four results are buffered, then drain one per cycle when ready.
// A last point that finds the buffer still draining waits in the square stage,
// holding in_bus.ready low until the cycle after the rank 3 word is taken.
// Synchronous reset: slots start at the default radius squared, probe at zero.
// A radius write takes effect at the next query.

module nearest_four_grid_search import nfg_pkg::*; #(
  parameter int MAX_ROWS = NFG_MAX_ROWS,
  parameter int MAX_COLS = NFG_MAX_COLS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  nfg_in_if.sink                in_bus,
  nfg_out_if.source             out_bus,
  input  wire logic             cfg_we,
  input  wire logic [DistW-1:0] cfg_wdata
);

  logic [DistW-1:0] radius_r;
  nfg_item_t        item;
  nfg_pt_t          pt;
  nfg_slots_t       slots;
  nfg_slots_t       slots_nxt;
  logic             emit_busy;
  logic             adv;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RadiusReset;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // pipeline holds only when a last point meets a busy result buffer
  assign adv          = !(pt.valid && pt.emit && emit_busy);
  assign in_bus.ready = adv;

  always_comb begin
    item.req_type = in_bus.req_type;
    item.north    = in_bus.coord_north;
    item.east     = in_bus.coord_east;
    item.row      = in_bus.point_row;
    item.col      = in_bus.point_col;
    item.last     = in_bus.last_point;
  end

  nfg_dist #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .take  (in_bus.valid),
    .item  (item),
    .pt    (pt)
  );

  nfg_rank u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .pt        (pt),
    .radius    (radius_r),
    .slots     (slots),
    .slots_nxt (slots_nxt)
  );

  nfg_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && pt.valid && pt.emit),
    .slots_nxt (slots_nxt),
    .out_bus   (out_bus),
    .busy      (emit_busy)
  );

  // slots stay in ascending order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    slots.dsq[0] <= slots.dsq[1] && slots.dsq[1] <= slots.dsq[2] &&
    slots.dsq[2] <= slots.dsq[3])
    else $error("slot distances out of order");

  // input stalls only while results are pending
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with no results pending");

  // ranks advance by one within a burst
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && !out_bus.last_result |=>
      out_bus.valid && out_bus.rank == $past(out_bus.rank) + RankW'(1))
    else $error("result burst broken");

  // a burst ends with an empty buffer
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && out_bus.last_result |=> !out_bus.valid)
    else $error("result buffer reloaded while draining");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import nfg_pkg::*;

  // top of the allowed radius range, 2^49
  localparam logic [DistW-1:0] RadiusTop = 50'h2000000000000;
  // far corner against near corner: 2 * (2^24 - 1)^2
  localparam logic [DistW-1:0] CornerDist = RadiusTop - 50'd67108862;
  localparam int StallLimit = 4000;
  localparam int RandomWords = 470;

  typedef enum logic {RowWord, RowRadius} row_kind_t;

  // one result word as the block should send it
  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DistW-1:0] dsq;
    logic             found;
    logic             last;
  } nbr_t;

  // one line of stimulus; typed results replace the predicted ones
  typedef struct {
    row_kind_t                     kind;
    nfg_item_t                     word;
    logic [DistW-1:0]              radius;
    bit                            typed;
    logic                          t_found;
    logic [DistW-1:0]              t_dist;
    logic [NumSlots-1:0][IdxW-1:0] t_row;
    logic [NumSlots-1:0][IdxW-1:0] t_col;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [DistW-1:0] cfg_wdata;

  nfg_in_if  in_bus();
  nfg_out_if out_bus();

  nearest_four_grid_search i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state: probe, radius and the four ranked slots
  logic signed [CoordW-1:0] probe_n;
  logic signed [CoordW-1:0] probe_e;
  logic [DistW-1:0]         search_radius;
  logic [DistW-1:0]         best_dist [NumSlots];
  logic [IdxW-1:0]          best_row  [NumSlots];
  logic [IdxW-1:0]          best_col  [NumSlots];
  logic                     best_used [NumSlots];
  nbr_t                     nbr_out   [NumSlots];

  nbr_t      awaited_neighbors[$];
  stim_row_t script[$];
  int        errors;
  int        words_sent;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic load_slots(input logic [DistW-1:0] start);
    int k;
    for (k = 0; k < NumSlots; k++) begin
      best_dist[k] = start;
      best_row[k]  = '0;
      best_col[k]  = '0;
      best_used[k] = 1'b0;
    end
  endtask

  // advance the search by one input word; emits is set on a closing point
  task automatic rank_search_step(input nfg_item_t w, output bit emits);
    longint           dn;
    longint           de;
    logic [DistW-1:0] d;
    int               k;
    int               m;
    bit               placed;
    bit               all4;
    emits = 1'b0;
    if (w.req_type == ReqQuery) begin
      probe_n = w.north;
      probe_e = w.east;
      load_slots(search_radius);
      return;
    end
    if (int'(w.row) < NFG_MAX_ROWS && int'(w.col) < NFG_MAX_COLS) begin
      dn = longint'($signed(w.north)) - longint'(probe_n);
      de = longint'($signed(w.east)) - longint'(probe_e);
      d = DistW'(dn * dn + de * de);
      placed = 1'b0;
      // first slot that is strictly farther takes the point
      for (k = 0; k < NumSlots && !placed; k++) begin
        if (d < best_dist[k]) begin
          for (m = NumSlots - 1; m > k; m--) begin
            best_dist[m] = best_dist[m-1];
            best_row[m]  = best_row[m-1];
            best_col[m]  = best_col[m-1];
            best_used[m] = best_used[m-1];
          end
          best_dist[k] = d;
          best_row[k]  = w.row;
          best_col[k]  = w.col;
          best_used[k] = 1'b1;
          placed = 1'b1;
        end
      end
    end
    if (!w.last) return;
    emits = 1'b1;
    all4 = 1'b1;
    for (k = 0; k < NumSlots; k++)
      if (!best_used[k]) all4 = 1'b0;
    for (k = 0; k < NumSlots; k++) begin
      nbr_out[k].rank  = RankW'(k);
      nbr_out[k].row   = all4 ? best_row[k] : '0;
      nbr_out[k].col   = all4 ? best_col[k] : '0;
      nbr_out[k].dsq   = best_dist[k];
      nbr_out[k].found = all4;
      nbr_out[k].last  = (k == NumSlots - 1);
    end
  endtask

  function automatic nfg_item_t mk_word(logic req, int n, int e, int r, int c, logic last);
    nfg_item_t w;
    w.req_type = req;
    w.north    = n[CoordW-1:0];
    w.east     = e[CoordW-1:0];
    w.row      = r[IdxW-1:0];
    w.col      = c[IdxW-1:0];
    w.last     = last;
    return w;
  endfunction

  function automatic stim_row_t mk_row(row_kind_t kind, nfg_item_t w, logic [DistW-1:0] v);
    stim_row_t s;
    s.kind    = kind;
    s.word    = w;
    s.radius  = v;
    s.typed   = 1'b0;
    s.t_found = 1'b0;
    s.t_dist  = '0;
    s.t_row   = '0;
    s.t_col   = '0;
    return s;
  endfunction

  task automatic add_item(input logic req, input int n, input int e, input int r,
                          input int c, input logic last);
    script.push_back(mk_row(RowWord, mk_word(req, n, e, r, c, last), '0));
  endtask

  // pin the results of the last line to values read straight off the spec
  task automatic mark_typed(input logic found, input logic [DistW-1:0] dist_v,
                            input logic [NumSlots-1:0][IdxW-1:0] rows,
                            input logic [NumSlots-1:0][IdxW-1:0] cols);
    stim_row_t s;
    s = script.pop_back();
    s.typed   = 1'b1;
    s.t_found = found;
    s.t_dist  = dist_v;
    s.t_row   = rows;
    s.t_col   = cols;
    script.push_back(s);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  // coordinate within spread of base, clipped to the 24 bit range
  function automatic int near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(0, 3))
      0:       return 4;
      1:       return 2000;
      2:       return 1 << 20;
      default: return 1 << 24;
    endcase
  endfunction

  // drive one word in bursts with random gaps, then predict on acceptance
  task automatic send(input stim_row_t s);
    bit   emits;
    nbr_t nbr;
    int   gap;
    int   k;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_bus.req_type    = s.word.req_type;
    in_bus.coord_north = s.word.north;
    in_bus.coord_east  = s.word.east;
    in_bus.point_row   = s.word.row;
    in_bus.point_col   = s.word.col;
    in_bus.last_point  = s.word.last;
    in_bus.valid       = 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    rank_search_step(s.word, emits);
    if (emits) begin
      for (k = 0; k < NumSlots; k++) begin
        nbr = nbr_out[k];
        if (s.typed) begin
          nbr.row   = s.t_row[k];
          nbr.col   = s.t_col[k];
          nbr.dsq   = s.t_dist;
          nbr.found = s.t_found;
        end
        awaited_neighbors.push_back(nbr);
      end
    end
    words_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_word(input nfg_item_t w);
    send(mk_row(RowWord, w, '0));
  endtask

  // let every result drain and the pipeline settle
  task automatic drain();
    in_bus.valid = 1'b0;
    burst_left = 0;
    while (awaited_neighbors.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_radius(input logic [DistW-1:0] v);
    drain();
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    search_radius = v;
  endtask

  // result checker
  always @(posedge clk) begin
    nbr_t got;
    nbr_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      got.rank  = out_bus.rank;
      got.row   = out_bus.near_row;
      got.col   = out_bus.near_col;
      got.dsq   = out_bus.dist_squared;
      got.found = out_bus.found;
      got.last  = out_bus.last_result;
      if (awaited_neighbors.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: rank %0d row %0d col %0d dist %0d found %0b last %0b",
                   got.rank, got.row, got.col, got.dsq, got.found, got.last);
      end else begin
        want = awaited_neighbors.pop_front();
        if (got.rank !== want.rank || got.row !== want.row || got.col !== want.col ||
            got.dsq !== want.dsq || got.found !== want.found || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp: rank %0d row %0d col %0d dist %0d found %0b last %0b",
                     want.rank, want.row, want.col, want.dsq, want.found, want.last);
            $display("         got: rank %0d row %0d col %0d dist %0d found %0b last %0b",
                     got.rank, got.row, got.col, got.dsq, got.found, got.last);
          end
        end
      end
    end
  end

  // receiver stalls: always ready, coin flip, or mostly stalled, in spans
  initial begin : result_stall
    int mode;
    int span;
    out_bus.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_bus.ready = 1'b1;
          1:       out_bus.ready = 1'($urandom_range(0, 1));
          default: out_bus.ready = ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no traffic at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int               i;
    int               n;
    int               pick;
    int               spread;
    int               pn;
    int               pe;
    logic [DistW-1:0] rv;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.req_type    = ReqQuery;
    in_bus.coord_north = '0;
    in_bus.coord_east  = '0;
    in_bus.point_row   = '0;
    in_bus.point_col   = '0;
    in_bus.last_point  = 1'b0;
    errors        = 0;
    words_sent    = 0;
    burst_left    = 0;
    probe_n       = '0;
    probe_e       = '0;
    search_radius = RadiusReset;
    load_slots(RadiusReset);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: points before any query see the reset slots and a zero probe
    add_item(ReqPoint, -8388608, -8388608, 1023, 1023, 1'b1);
    mark_typed(1'b0, RadiusReset, '0, '0);
    add_item(ReqPoint, 0, 0, 0, 0, 1'b0);
    add_item(ReqPoint, 3, 4, 1, 2, 1'b0);
    // equal distance goes behind the earlier point
    add_item(ReqPoint, 3, 4, 3, 4, 1'b1);
    // slots survive the emission, the fourth fill flips found
    add_item(ReqPoint, -1, 0, 5, 6, 1'b1);
    // a query with last set emits nothing
    add_item(ReqQuery, 8388607, -8388608, 7, 9, 1'b1);
    add_item(ReqPoint, 8388607, -8388608, 1023, 0, 1'b1);
    // zero radius: nothing is strictly closer
    script.push_back(mk_row(RowRadius, '0, '0));
    add_item(ReqQuery, 0, 0, 0, 0, 1'b0);
    add_item(ReqPoint, 0, 0, 1, 1, 1'b1);
    mark_typed(1'b0, '0, '0, '0);
    // widest radius, opposite corners, four ties kept in arrival order
    script.push_back(mk_row(RowRadius, '0, RadiusTop));
    add_item(ReqQuery, 8388607, 8388607, 0, 0, 1'b0);
    add_item(ReqPoint, -8388608, -8388608, 10, 11, 1'b0);
    add_item(ReqPoint, -8388608, -8388608, 20, 21, 1'b0);
    add_item(ReqPoint, -8388608, -8388608, 30, 31, 1'b0);
    add_item(ReqPoint, -8388608, -8388608, 40, 41, 1'b1);
    mark_typed(1'b1, CornerDist, {10'd40, 10'd30, 10'd20, 10'd10},
               {10'd41, 10'd31, 10'd21, 10'd11});
    add_item(ReqPoint, 8388607, 8388607, 1023, 1023, 1'b1);
    script.push_back(mk_row(RowRadius, '0, RadiusReset));
    add_item(ReqQuery, 100, -100, 0, 0, 1'b0);
    add_item(ReqPoint, 101, -100, 2, 3, 1'b0);
    add_item(ReqPoint, 100, -98, 4, 5, 1'b1);

    foreach (script[j]) begin
      if (script[j].kind == RowRadius)
        write_radius(script[j].radius);
      else
        send(script[j]);
    end

    // random phases: a radius, then a handful of scans
    pn = 0;
    pe = 0;
    while (words_sent < RandomWords) begin
      case ($urandom_range(0, 6))
        0:       rv = RadiusReset;
        1:       rv = RadiusTop;
        2:       rv = {1'b0, 17'($urandom), $urandom};
        3:       rv = DistW'($urandom_range(0, 16000000));
        4:       rv = '0;
        default: rv = {8'd0, 10'($urandom), $urandom};
      endcase
      write_radius(rv);
      repeat ($urandom_range(2, 6)) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          // well-formed scan: query then points ending on a last point
          pn = ($urandom_range(0, 3) == 0) ? near(0, 2000) : rand_coord();
          pe = ($urandom_range(0, 3) == 0) ? near(0, 2000) : rand_coord();
          spread = pick_spread();
          send_word(mk_word(ReqQuery, pn, pe, $urandom_range(0, 1023),
                            $urandom_range(0, 1023), 1'($urandom_range(0, 1))));
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
          for (i = 0; i < n; i++)
            send_word(mk_word(ReqPoint,
                              near(pn, ($urandom_range(0, 4) == 0) ? pick_spread() : spread),
                              near(pe, spread), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), i == n - 1));
        end else if (pick < 15) begin
          // more points into the slots kept from the last scan
          n = $urandom_range(1, 4);
          spread = pick_spread();
          for (i = 0; i < n; i++)
            send_word(mk_word(ReqPoint, near(pn, spread), near(pe, spread),
                              $urandom_range(0, 1023), $urandom_range(0, 1023), i == n - 1));
        end else if (pick < 18) begin
          // broken scan: last bits anywhere, or none at all
          pn = rand_coord();
          pe = rand_coord();
          spread = pick_spread();
          send_word(mk_word(ReqQuery, pn, pe, 0, 0, 1'b0));
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++)
            send_word(mk_word(ReqPoint, near(pn, spread), near(pe, spread),
                              $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 2) == 0));
        end else begin
          // noise words
          repeat ($urandom_range(1, 6))
            send_word(mk_word(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                              $urandom_range(0, 1023), $urandom_range(0, 1023),
                              1'($urandom_range(0, 1))));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
